FILE: hdl/bfa_pkg.sv
// Shared constants, codes and controller/datapath interface types of the bitmap allocator.
package bfa_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = MAP_BITS / WORD_W;
    localparam int WORD_AW   = $clog2(NUM_WORDS);
    localparam int BIT_AW    = $clog2(WORD_W);
    localparam int IDX_W     = WORD_AW + BIT_AW;
    localparam int LIM_W     = IDX_W + 1;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = LIM_W;

    localparam logic [CFG_AW-1:0] CFG_SEARCH_START = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_BITS_IN_USE  = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC     = 2'd0,
        KIND_MARK_USED = 2'd1,
        KIND_MARK_FREE = 2'd2,
        KIND_QUERY     = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_WORD,
        RES_NO_SPACE,
        RES_RANGE
    } res_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load;      // latch an accepted request
        logic     rd_en;     // read the current scan word, advance the scan pointer
        logic     commit;    // write back the updated word
        logic     res_load;  // capture a result
        res_sel_t res_sel;
        logic     out_load;  // move the captured result to the output register
    } bfa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic alloc;      // request is an allocate
        logic no_start;   // search start at or past the limit
        logic range_err;  // named index at or past the limit
        logic found;      // word under test holds a free bit in the window
        logic last_word;  // word under test is the last one below the limit
    } bfa_stat_t;

endpackage

FILE: hdl/bitmap_first_free_allocator.sv
// Top level of the first-fit bitmap allocator: stream ports, controller and datapath.
// Flow: a mark/query request reads its one map word and returns a result; an allocate scans
// N 32-bit map words (1 to 32); out-of-range or a start past the limit skips the map read.
// One request at a time; the single map RAM read port scans one word per cycle, and a held
// result adds stalls before the next request is taken.
// Reset: search_start = 0, bits_in_use = 1024, map empty at once through per-word written flags.
module bitmap_first_free_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic [bfa_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [bfa_pkg::CFG_DW-1:0] cfg_wr_data,
    // request stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,   // [9:0] bit_index, [15:10] zero
    input  logic [1:0]                 s_axis_tuser,   // [1:0] kind
    // result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [9:0] result_index, [10] was_used
    output logic [1:0]                 m_axis_tuser    // [1:0] status
);
    import bfa_pkg::*;

    bfa_cmd_t           cmd;
    bfa_stat_t          stat;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    result_index;
    logic                was_used;

    // Controller: accepts one request, walks it through lookup, scan and result hand-off
    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: map RAM, window masks, first-free encoder and output register
    bfa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .in_kind          (s_axis_tuser),
        .in_bit_index     (s_axis_tdata[IDX_W-1:0]),
        .cmd              (cmd),
        .stat             (stat),
        .out_status       (status),
        .out_result_index (result_index),
        .out_was_used     (was_used)
    );

    // Pack the result beat; upper bits stay zero
    assign m_axis_tdata = {{(16 - IDX_W - 1){1'b0}}, was_used, result_index};
    assign m_axis_tuser = status;

    // One request in flight: the port closes right after a beat is taken
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // No-space results carry index 0 and a clear was_used flag
    a_no_space_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NO_SPACE) |-> (m_axis_tdata == '0))
        else $error("no-space result with nonzero payload");

    // Out-of-range results never report the bit as used
    a_range_was_used: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_RANGE) |-> !m_axis_tdata[IDX_W])
        else $error("out-of-range result reports was_used");

    // A map write only happens when a result is captured
    a_commit_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> cmd.res_load && !cmd.rd_en)
        else $error("map write without result capture");

endmodule

FILE: hdl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/bfa_ctrl.sv
// Request sequencer of the bitmap allocator.
module bfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bfa_pkg::bfa_stat_t stat,
    output bfa_pkg::bfa_cmd_t  cmd
);
    import bfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.res_sel = RES_WORD;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (stat.alloc && stat.no_start)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NO_SPACE;
                    state_next   = S_FINISH;
                end
                else if (!stat.alloc && stat.range_err)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_RANGE;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.alloc || stat.found)
                begin
                    cmd.commit   = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (stat.last_word)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NO_SPACE;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/bfa_datapath.sv
// Bitmap storage, word scan logic, configuration and result registers of the allocator.
module bfa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bfa_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [bfa_pkg::CFG_DW-1:0]    cfg_wr_data,
    input  logic [bfa_pkg::KIND_W-1:0]    in_kind,
    input  logic [bfa_pkg::IDX_W-1:0]     in_bit_index,
    input  bfa_pkg::bfa_cmd_t             cmd,
    output bfa_pkg::bfa_stat_t            stat,
    output logic [bfa_pkg::STATUS_W-1:0]  out_status,
    output logic [bfa_pkg::IDX_W-1:0]     out_result_index,
    output logic                          out_was_used
);
    import bfa_pkg::*;

    function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_AW-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BIT_AW'(i);
            end
        end
        return r;
    endfunction

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    logic [IDX_W-1:0]     search_start_reg;
    logic [LIM_W-1:0]     bits_in_use_reg;
    kind_t                kind_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [WORD_AW-1:0]   scan_word_reg;
    logic [WORD_AW-1:0]   pend_word_reg;
    logic                 pend_valid_reg;
    logic [NUM_WORDS-1:0] word_valid_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [IDX_W-1:0]     res_index_reg;
    logic                 res_used_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [IDX_W-1:0]     out_index_reg;
    logic                 out_used_reg;

    logic [LIM_W-1:0]   lim;
    logic [LIM_W-1:0]   lim_m1;
    logic [WORD_AW-1:0] start_word;
    logic [WORD_AW-1:0] last_word;
    logic [WORD_W-1:0]  ram_rd;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  free_vec;
    logic [BIT_AW-1:0]  free_bit;
    logic [BIT_AW-1:0]  bit_sel;
    logic [WORD_W-1:0]  bit_onehot;
    logic [WORD_W-1:0]  wr_word;
    logic               wr_en;
    logic               old_bit;

    // Effective limit saturates at the map size
    assign lim = (bits_in_use_reg > LIM_W'(MAP_BITS)) ? LIM_W'(MAP_BITS) : bits_in_use_reg;
    assign lim_m1     = lim - LIM_W'(1);
    assign start_word = search_start_reg[BIT_AW +: WORD_AW];
    assign last_word  = lim_m1[BIT_AW +: WORD_AW];

    // A word never written since reset reads as all free
    assign word = pend_valid_reg ? ram_rd : '0;

    assign lo_mask = (pend_word_reg == start_word)
                     ? (ONES << search_start_reg[BIT_AW-1:0]) : ONES;
    assign hi_mask = (pend_word_reg == last_word)
                     ? (ONES >> (BIT_AW'(WORD_W - 1) - lim_m1[BIT_AW-1:0])) : ONES;
    assign free_vec = ~word & lo_mask & hi_mask;
    assign free_bit = lowest_set(free_vec);

    assign bit_sel    = (kind_reg == KIND_ALLOC) ? free_bit : idx_reg[BIT_AW-1:0];
    assign bit_onehot = WORD_W'(1) << bit_sel;
    assign old_bit    = word[bit_sel];

    always_comb
    begin
        case (kind_reg)
            KIND_ALLOC, KIND_MARK_USED: wr_word = word | bit_onehot;
            KIND_MARK_FREE:             wr_word = word & ~bit_onehot;
            default:                    wr_word = word;
        endcase
    end

    assign wr_en = cmd.commit && (kind_reg != KIND_QUERY);

    assign stat.alloc     = (kind_reg == KIND_ALLOC);
    assign stat.no_start  = ({1'b0, search_start_reg} >= lim);
    assign stat.range_err = ({1'b0, idx_reg} >= lim);
    assign stat.found     = |free_vec;
    assign stat.last_word = (pend_word_reg == last_word);

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pend_word_reg),
        .wr_data (wr_word),
        .rd_en   (cmd.rd_en),
        .rd_addr (scan_word_reg),
        .rd_data (ram_rd)
    );

    // Configuration and per-word written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_start_reg <= '0;
            bits_in_use_reg  <= LIM_W'(MAP_BITS);
            word_valid_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_addr == CFG_SEARCH_START))
            begin
                search_start_reg <= cfg_wr_data[IDX_W-1:0];
            end
            if (cfg_wr_en && (cfg_addr == CFG_BITS_IN_USE))
            begin
                bits_in_use_reg <= cfg_wr_data[LIM_W-1:0];
            end
            if (wr_en)
            begin
                word_valid_reg[pend_word_reg] <= 1'b1;
            end
        end
    end

    // Request, scan pointer and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(in_kind);
            idx_reg  <= in_bit_index;
            scan_word_reg <= (kind_t'(in_kind) == KIND_ALLOC)
                             ? start_word : in_bit_index[BIT_AW +: WORD_AW];
        end
        else if (cmd.rd_en)
        begin
            scan_word_reg <= scan_word_reg + WORD_AW'(1);
        end
        if (cmd.rd_en)
        begin
            pend_word_reg  <= scan_word_reg;
            pend_valid_reg <= word_valid_reg[scan_word_reg];
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_NO_SPACE:
                begin
                    res_status_reg <= ST_NO_SPACE;
                    res_index_reg  <= '0;
                    res_used_reg   <= 1'b0;
                end
                RES_RANGE:
                begin
                    res_status_reg <= ST_RANGE;
                    res_index_reg  <= idx_reg;
                    res_used_reg   <= 1'b0;
                end
                default:
                begin
                    res_status_reg <= ST_OK;
                    if (kind_reg == KIND_ALLOC)
                    begin
                        res_index_reg <= {pend_word_reg, free_bit};
                        res_used_reg  <= 1'b0;
                    end
                    else
                    begin
                        res_index_reg <= idx_reg;
                        res_used_reg  <= old_bit;
                    end
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_used_reg   <= res_used_reg;
        end
    end

    assign out_status       = out_status_reg;
    assign out_result_index = out_index_reg;
    assign out_was_used     = out_used_reg;

endmodule

FILE: sim/bfa_reply_checker.sv
// Reply checker for the bitmap allocator: mirrors the map and compares every result beat.
`timescale 1ns / 100ps

module bfa_reply_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bfa_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [bfa_pkg::CFG_DW-1:0]  cfg_wr_data,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [9:0] bit_index, [15:10] zero
    input  logic [1:0]                  s_axis_tuser,   // [1:0] kind
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [15:0]                 m_axis_tdata,   // [9:0] result_index, [10] was_used
    input  logic [1:0]                  m_axis_tuser,   // [1:0] status
    output int                          error_count,
    output int                          outstanding
);
    import bfa_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] index;
        logic             used;
    } reply_t;

    logic             occupied [MAP_BITS];
    logic [IDX_W-1:0] first_alloc;
    logic [LIM_W-1:0] managed_bits;
    reply_t           awaited_replies [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        error_count++;
    endtask

    // Apply one request to the mirrored map and return the reply it should produce.
    function automatic reply_t serve_request(input kind_t kind, input logic [IDX_W-1:0] idx);
        int     window;
        int     i;
        reply_t r;
        window   = (int'(managed_bits) > MAP_BITS) ? MAP_BITS : int'(managed_bits);
        r.status = ST_OK;
        r.index  = idx;
        r.used   = 1'b0;
        if (kind == KIND_ALLOC)
        begin
            r.status = ST_NO_SPACE;
            r.index  = '0;
            for (i = int'(first_alloc); i < window && r.status != ST_OK; i++)
            begin
                if (!occupied[i])
                begin
                    occupied[i] = 1'b1;
                    r.status    = ST_OK;
                    r.index     = IDX_W'(i);
                end
            end
        end
        else if (int'(idx) >= window)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            r.used = occupied[idx];
            if (kind == KIND_MARK_USED)
                occupied[idx] = 1'b1;
            else if (kind == KIND_MARK_FREE)
                occupied[idx] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            foreach (occupied[i])
                occupied[i] = 1'b0;
            first_alloc  = '0;
            managed_bits = LIM_W'(MAP_BITS);
            awaited_replies.delete();
            error_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_SEARCH_START: first_alloc  = cfg_wr_data[IDX_W-1:0];
                    CFG_BITS_IN_USE:  managed_bits = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_replies.push_back(serve_request(kind_t'(s_axis_tuser),
                                                        s_axis_tdata[IDX_W-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tuser);
                got.index  = m_axis_tdata[IDX_W-1:0];
                got.used   = m_axis_tdata[IDX_W];
                if (awaited_replies.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with nothing pending (status %0d index %0d)",
                                              got.status, got.index));
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.index != want.index)
                        report_mismatch($sformatf("result_index %0d, expected %0d",
                                                  got.index, want.index));
                    if (got.used != want.used)
                        report_mismatch($sformatf("was_used %0b, expected %0b (index %0d)",
                                                  got.used, want.used, want.index));
                end
            end
            outstanding <= awaited_replies.size();
        end
    end

endmodule

FILE: sim/bitmap_first_free_allocator_test.sv
// Top of the bitmap allocator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module bitmap_first_free_allocator_test;

    import bfa_pkg::*;

    // Register slots past the two real ones; writes there must be dropped by the block.
    localparam logic [CFG_AW-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SPARE_3 = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SEGMENTS     = 8;
    localparam int SEGMENT_REQS = 104;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CFG_AW-1:0] cfg_addr      = CFG_SEARCH_START;
    logic [CFG_DW-1:0] cfg_wr_data   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;   // [9:0] bit_index, [15:10] zero
    logic [1:0]        s_axis_tuser  = '0;   // [1:0] kind
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;         // [9:0] result_index, [10] was_used
    logic [1:0]        m_axis_tuser;         // [1:0] status

    int error_count;
    int outstanding;
    int cycle_count   = 0;
    int send_idle_pct = 0;   // chance per cycle that the request side holds off
    int stall_pct     = 0;   // chance per cycle that the result side stalls
    int cur_window    = MAP_BITS;  // effective limit as last programmed

    always #6 clk = ~clk;

    bitmap_first_free_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bfa_reply_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    // Result side: stall at random according to the current phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive one request beat; hold valid low for a random gap first, then hold the
    // beat until the block takes it. Valid stays high on return so that a following
    // request with no gap goes out back to back.
    task automatic send_request(input kind_t kind, input logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(16 - IDX_W){1'b0}}, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid and wait until every pending result has come back, then let the
    // block settle before the registers change.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Program both registers and poke one spare slot with junk. Bit 10 of the
    // search_start write is random: the register keeps only the low 10 bits.
    task automatic program_window(input logic [IDX_W-1:0] start, input logic [LIM_W-1:0] bits);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_SEARCH_START;
        cfg_wr_data <= {1'($urandom_range(0, 1)), start};
        @(posedge clk);
        cfg_addr    <= CFG_BITS_IN_USE;
        cfg_wr_data <= bits;
        @(posedge clk);
        cfg_addr    <= $urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3;
        cfg_wr_data <= CFG_DW'($urandom);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_window  = (int'(bits) > MAP_BITS) ? MAP_BITS : int'(bits);
    endtask

    // Random request: allocate-heavy with plenty of frees so the window fills,
    // empties and refills. Indexes mostly land near the window, some anywhere.
    task automatic send_random_request;
        kind_t            kind;
        logic [IDX_W-1:0] idx;
        int               pick;
        int               top_idx;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            kind = KIND_ALLOC;
        else if (pick < 60)
            kind = KIND_MARK_USED;
        else if (pick < 85)
            kind = KIND_MARK_FREE;
        else
            kind = KIND_QUERY;
        top_idx = (cur_window + 2 > MAP_BITS - 1) ? MAP_BITS - 1 : cur_window + 2;
        if ($urandom_range(0, 99) < 80)
            idx = IDX_W'($urandom_range(0, top_idx));
        else
            idx = IDX_W'($urandom);
        send_request(kind, idx);
    endtask

    initial
    begin
        logic [IDX_W-1:0] start;
        logic [LIM_W-1:0] bits;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, no idling, reset register values (start 0, full map).
        send_request(KIND_QUERY, 10'd0);       // free after reset
        send_request(KIND_ALLOC, 10'd0);       // gets 0
        send_request(KIND_ALLOC, 10'd1023);    // index ignored, gets 1
        send_request(KIND_MARK_USED, 10'd1023);
        send_request(KIND_QUERY, 10'd1023);    // now set
        send_request(KIND_MARK_FREE, 10'd1023);
        send_request(KIND_MARK_FREE, 10'd0);
        send_request(KIND_ALLOC, 10'd0);       // 0 again
        send_request(KIND_MARK_USED, 10'd2);
        send_request(KIND_ALLOC, 10'd0);       // skips 2, gets 3
        drain();

        // Search starts at the very last bit: one success, then no space.
        program_window(10'd1023, 11'd1024);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
        drain();

        // Zero limit: nothing can be allocated and every index is out of range.
        program_window(10'd0, 11'd0);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_QUERY, 10'd0);
        send_request(KIND_MARK_USED, 10'd5);
        drain();

        // Limit above the map size saturates; inode-style start.
        program_window(10'd11, 11'd2047);
        send_request(KIND_MARK_USED, 10'd1023);
        send_request(KIND_ALLOC, 10'd0);
        drain();

        // Start past the limit: allocate finds nothing; marks still follow the limit.
        program_window(10'd600, 11'd300);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_QUERY, 10'd299);
        send_request(KIND_MARK_USED, 10'd300);
        drain();

        // Limit inside a byte: bit 12 is still searched.
        program_window(10'd12, 11'd13);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
        drain();

        // Random part: one register setting per segment, idling phase by segment.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       begin start = 10'd0;                      bits = 11'd1024; end
                1:       begin start = 10'($urandom_range(0, 40)); bits = 11'($urandom_range(1, 64)); end
                2:       begin start = 10'd0;                      bits = 11'd1; end
                3:       begin start = 10'd1023;                   bits = 11'd2047; end
                4:       begin start = 10'($urandom);              bits = 11'($urandom); end
                5:       begin start = 10'($urandom_range(0, 20)); bits = 11'($urandom_range(8, 40)); end
                6:       begin start = 10'd0;                      bits = 11'd0; end
                default: begin start = 10'($urandom_range(0, 60)); bits = 11'($urandom_range(33, 100)); end
            endcase
            case (seg % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 79; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            program_window(start, bits);
            repeat (SEGMENT_REQS) send_random_request();
            drain();
        end

        stall_pct = 0;
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/bfa_ctrl.sv
hdl/bfa_datapath.sv
hdl/bitmap_first_free_allocator.sv
sim/bfa_reply_checker.sv
sim/bitmap_first_free_allocator_test.sv
